// ===== rtl/kcc_pkg.sv =====
// Package for the keyword category counter: widths, request and category
// codes, item and command types, the delimiter set and the keyword table.
// No dependencies.
package kcc_pkg;

  localparam int MAX_TOKEN_LEN  = 16;
  localparam int COUNT_BITS     = 32;
  localparam int COUNT_OUT_BITS = 32;
  localparam int NUM_CATS       = 14;
  localparam int TOK_BITS       = MAX_TOKEN_LEN * 8;
  localparam int LEN_BITS       = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [1:0] {
    REQ_CHAR   = 2'd0,
    REQ_EOL    = 2'd1,
    REQ_REPORT = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    CAT_TYPE        = 4'd0,
    CAT_CONDITIONAL = 4'd1,
    CAT_LOOP        = 4'd2,
    CAT_STRUCTURE   = 4'd3,
    CAT_MEMBER      = 4'd4,
    CAT_NAMESPACE   = 4'd5,
    CAT_CAST        = 4'd6,
    CAT_MEMORY      = 4'd7,
    CAT_EXCEPTION   = 4'd8,
    CAT_MISC        = 4'd9,
    CAT_ASM         = 4'd10,
    CAT_GOTO        = 4'd11,
    CAT_MUTABLE     = 4'd12,
    CAT_UNION       = 4'd13
  } cat_e;

  typedef enum logic {
    CMD_BUMP   = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                category;
    logic [COUNT_OUT_BITS-1:0] count;
    logic                      last_of_report;
  } out_item_t;

  // One command from the front to the back: a counter bump or a report.
  typedef struct packed {
    cmd_kind_e kind;
    cat_e      cat;
    logic      has_extra;
    cat_e      extra;
  } cmd_t;

  typedef struct packed {
    logic hit;
    cat_e cat;
    logic has_extra;
    cat_e extra;
  } match_t;

  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    unique case (c)
      8'h00, 8'h09, 8'h0D, 8'h20, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3C,
      8'h3E, 8'h3B, 8'h3D, 8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h21, 8'h25,
      8'h5E, 8'h26, 8'h7C, 8'h3A, 8'h2C, 8'h2E, 8'h3F, 8'h7E: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  // The token is held right-justified with zero bytes above it. Token
  // characters are never zero, so the value alone fixes both text and length.
  function automatic match_t kw_match(input logic [TOK_BITS-1:0] tok);
    match_t m;
    m.hit       = 1'b1;
    m.cat       = CAT_TYPE;
    m.has_extra = 1'b0;
    m.extra     = CAT_TYPE;
    unique case (tok)
      TOK_BITS'("auto"), TOK_BITS'("bool"), TOK_BITS'("char"),
      TOK_BITS'("char8_t"), TOK_BITS'({"char16", "_t"}), TOK_BITS'({"char32", "_t"}),
      TOK_BITS'("const"), TOK_BITS'("double"), TOK_BITS'("extern"),
      TOK_BITS'("float"), TOK_BITS'("inline"), TOK_BITS'("int"),
      TOK_BITS'("long"), TOK_BITS'("noexcept"), TOK_BITS'("short"),
      TOK_BITS'("static"), TOK_BITS'("unsigned"), TOK_BITS'("volatile"),
      TOK_BITS'("wchar_t"): m.cat = CAT_TYPE;
      TOK_BITS'("case"), TOK_BITS'("default"), TOK_BITS'("if"),
      TOK_BITS'("else"), TOK_BITS'("switch"): m.cat = CAT_CONDITIONAL;
      TOK_BITS'("do"), TOK_BITS'("for"), TOK_BITS'("while"): m.cat = CAT_LOOP;
      TOK_BITS'("class"), TOK_BITS'("enum"), TOK_BITS'("struct"):
        m.cat = CAT_STRUCTURE;
      TOK_BITS'("explicit"), TOK_BITS'("friend"), TOK_BITS'("operator"),
      TOK_BITS'("private"), TOK_BITS'("protected"), TOK_BITS'("public"):
        m.cat = CAT_MEMBER;
      TOK_BITS'("namespace"), TOK_BITS'("using"): m.cat = CAT_NAMESPACE;
      TOK_BITS'({"const", "_cast"}), TOK_BITS'({"dynamic", "_cast"}),
      TOK_BITS'({"reinterpret", "_cast"}), TOK_BITS'({"static", "_cast"}):
        m.cat = CAT_CAST;
      TOK_BITS'("delete"), TOK_BITS'("new"): m.cat = CAT_MEMORY;
      TOK_BITS'("catch"), TOK_BITS'("throw"), TOK_BITS'("try"):
        m.cat = CAT_EXCEPTION;
      TOK_BITS'("constexpr"), TOK_BITS'("return"), TOK_BITS'("sizeof"),
      TOK_BITS'("template"): m.cat = CAT_MISC;
      TOK_BITS'("asm"): begin
        m.cat       = CAT_MISC;
        m.has_extra = 1'b1;
        m.extra     = CAT_ASM;
      end
      TOK_BITS'("goto"): begin
        m.cat       = CAT_CONDITIONAL;
        m.has_extra = 1'b1;
        m.extra     = CAT_GOTO;
      end
      TOK_BITS'("mutable"): begin
        m.cat       = CAT_TYPE;
        m.has_extra = 1'b1;
        m.extra     = CAT_MUTABLE;
      end
      TOK_BITS'("union"): begin
        m.cat       = CAT_STRUCTURE;
        m.has_extra = 1'b1;
        m.extra     = CAT_UNION;
      end
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/kcc_front.sv =====
// Front end of the keyword category counter: accepts items, assembles tokens
// and classifies each finished token into a command. Depends on kcc_pkg.
module kcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kcc_pkg::in_item_t in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output kcc_pkg::cmd_t     cmd_o
);
  import kcc_pkg::*;

  logic [TOK_BITS-1:0] tok_q, tok_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                overlong_q, overlong_d;
  logic                accept, finish, is_char, is_report;
  match_t              m;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_char    = (in_i.req_type == REQ_CHAR);
  assign is_report  = (in_i.req_type == REQ_REPORT);
  assign finish     = accept && ((is_char && is_delim(in_i.char_code)) ||
                                 (in_i.req_type == REQ_EOL));
  assign m          = kw_match(tok_q);

  always_comb begin
    tok_d      = tok_q;
    len_d      = len_q;
    overlong_d = overlong_q;
    if (finish) begin
      tok_d      = '0;
      len_d      = '0;
      overlong_d = 1'b0;
    end else if (accept && is_char) begin
      if (len_q == LEN_BITS'(MAX_TOKEN_LEN)) begin
        overlong_d = 1'b1;
      end else begin
        tok_d = {tok_q[TOK_BITS-9:0], in_i.char_code};
        len_d = len_q + 1'b1;
      end
    end
  end

  always_comb begin
    cmd_o.kind      = is_report ? CMD_REPORT : CMD_BUMP;
    cmd_o.cat       = m.cat;
    cmd_o.has_extra = m.has_extra;
    cmd_o.extra     = m.extra;
    push_o = (accept && is_report) || (finish && !overlong_q && m.hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= '0;
      len_q      <= '0;
      overlong_q <= 1'b0;
    end else begin
      tok_q      <= tok_d;
      len_q      <= len_d;
      overlong_q <= overlong_d;
    end
  end

endmodule

// ===== rtl/kcc_cmd_fifo.sv =====
// Short command queue between the front and back ends of the keyword
// category counter. Depends on kcc_pkg.
module kcc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kcc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output kcc_pkg::cmd_t cmd_o
);
  import kcc_pkg::*;

  localparam int Depth    = 4;
  localparam int PtrBits  = $clog2(Depth);
  localparam int CntBits  = $clog2(Depth + 1);

  cmd_t               mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/kcc_back.sv =====
// Back end of the keyword category counter: holds the fourteen saturating
// counters, applies bumps and streams reports. Depends on kcc_pkg.
module kcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  kcc_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kcc_pkg::out_item_t out_o
);
  import kcc_pkg::*;

  localparam logic [3:0] LastCat = 4'(NUM_CATS - 1);

  logic [COUNT_BITS-1:0] cnt_q [NUM_CATS];
  logic [3:0]            idx_q;
  logic                  out_valid_q;
  out_item_t             out_q;
  logic                  out_free, do_report, do_bump;
  logic [63:0]           rd_ext;
  logic [COUNT_OUT_BITS-1:0] rd_sat;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_report = cmd_valid_i && (cmd_i.kind == CMD_REPORT) && out_free;
  assign do_bump   = cmd_valid_i && (cmd_i.kind == CMD_BUMP);
  assign pop_o     = do_bump || (do_report && (idx_q == LastCat));

  // A wide counter reads out clamped to the width of the count field.
  assign rd_ext = 64'(cnt_q[idx_q]);
  assign rd_sat = (rd_ext > 64'(COUNT_OUT_BITS'('1))) ? '1 : rd_ext[COUNT_OUT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CATS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CATS; k++) begin
        if (do_report && (idx_q == 4'(k))) begin
          cnt_q[k] <= '0;
        end else if (do_bump && ((cmd_i.cat == cat_e'(k)) ||
                                 (cmd_i.has_extra && (cmd_i.extra == cat_e'(k)))) &&
                     (cnt_q[k] != '1)) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_report) begin
        idx_q       <= (idx_q == LastCat) ? '0 : idx_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_report) begin
      out_q.category       <= idx_q;
      out_q.count          <= rd_sat;
      out_q.last_of_report <= (idx_q == LastCat);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/keyword_category_counter_top.sv =====
// Top level of the keyword category counter: front end, command queue and
// back end. Depends on kcc_pkg, kcc_front, kcc_cmd_fifo and kcc_back.

// The block takes one item per cycle while not stalled: characters, line
// ends and report requests. Tokens are built in the front end, and a
// finished token is matched against the keyword table in the cycle it
// ends; a hit becomes a counter bump in a four-entry command queue. The
// back end applies one bump per cycle, and a report occupies it until all
// fourteen counts are sent, one per cycle while the output is not stalled,
// clearing each counter as it is sent. During a report the front end keeps
// taking characters until four commands wait; only then is the input stalled.
module keyword_category_counter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kcc_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kcc_pkg::out_item_t out_o
);
  import kcc_pkg::*;

  logic q_full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  kcc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  kcc_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .cmd_o  (head_cmd)
  );

  kcc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

endmodule
